FILE: hdl/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int KEY_W    = 32;
  localparam int PRIO_W   = 16;
  localparam int PAY_W    = 32;
  localparam int COUNT_W  = 5;

  localparam int IN_DATA_W  = ((KEY_W + PRIO_W + PAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_W + PRIO_W + PAY_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STATUS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_CHANGE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

FILE: hdl/spq_store.sv
// Entry memory of the queue: one write port and one registered read port.
module spq_store (
  input  logic              clk,
  input  spq_pkg::mem_req_t req,
  output spq_pkg::entry_t   rd_data
);

  spq_pkg::entry_t entry_mem [spq_pkg::CAPACITY];
  spq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      entry_mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= entry_mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/sorted_priority_queue_by_key_unit.sv
// Top level of the sorted priority queue: sequencer around the entry memory.
//
// The input channel takes one command beat at a time: in_tuser carries the
// operation (insert, extract head, remove by key, change priority) and
// in_tdata the key, priority and payload. Every command gives exactly one
// result beat on the output channel with a status, the removed entry where
// there is one, and the occupancy after the operation.
// Entries sit in ascending priority order in a single memory with one read
// and one write port, visited one entry per cycle. Each command first
// searches all N entries held; a removal then closes the gap of the
// removed entry and an insert opens a gap at its place; change priority
// does both, reinserting the entry into the N - 1 entries left.
// in_tready is high only while no command is in progress. A finished result
// waits in the output register, and the next command is accepted while it
// waits; if the receiver is still stalling when that command completes, the
// sequencer holds until the earlier beat is taken.
// A synchronous reset empties the queue; the memory itself is not cleared.
module sorted_priority_queue_by_key_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // item_key, item_priority, item_payload
  input  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [spq_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_key, out_priority, out_payload, entry_count, zero padding
  output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata,
  // status, queue_empty
  output logic [spq_pkg::OUT_USER_W-1:0] out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DOWN,
    S_UP,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  spq_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [spq_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [spq_pkg::PRIO_W-1:0]    prio_r, prio_nxt;
  logic [spq_pkg::PAY_W-1:0]     pay_r, pay_nxt;
  logic [spq_pkg::CNT_W-1:0]     occ_r, occ_nxt;
  logic [spq_pkg::CNT_W-1:0]     ptr_r, ptr_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [spq_pkg::IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                          found_r, found_nxt;
  logic [spq_pkg::IDX_W-1:0]     pos_r, pos_nxt;
  logic [spq_pkg::CNT_W-1:0]     lt_cnt_r, lt_cnt_nxt;
  logic [spq_pkg::CNT_W-1:0]     ins_r, ins_nxt;
  spq_pkg::status_t              res_status_r, res_status_nxt;
  logic [spq_pkg::KEY_W-1:0]     res_key_r, res_key_nxt;
  logic [spq_pkg::PRIO_W-1:0]    res_prio_r, res_prio_nxt;
  logic [spq_pkg::PAY_W-1:0]     res_pay_r, res_pay_nxt;
  logic                          out_valid_r, out_valid_nxt;
  spq_pkg::status_t              out_status_r, out_status_nxt;
  logic [spq_pkg::KEY_W-1:0]     out_key_r, out_key_nxt;
  logic [spq_pkg::PRIO_W-1:0]    out_prio_r, out_prio_nxt;
  logic [spq_pkg::PAY_W-1:0]     out_pay_r, out_pay_nxt;
  logic                          out_empty_r, out_empty_nxt;
  logic [spq_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;

  spq_pkg::mem_req_t             mem_req;
  spq_pkg::entry_t               rd_entry;
  logic                          hit;
  logic                          below;
  logic                          found_below;
  logic [spq_pkg::CNT_W-1:0]     ins_calc;
  logic [spq_pkg::CNT_W-1:0]     ptr_dec;
  logic [spq_pkg::CNT_W-1:0]     pos_inc;

  spq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_entry)
  );

  assign hit = chk_vld_r && ((cmd_r == spq_pkg::CMD_EXTRACT) ? (chk_idx_r == '0)
                                                             : (rd_entry.key == key_r));
  assign below       = chk_vld_r && ($signed(rd_entry.prio) < $signed(prio_r));
  assign found_below = found_r && ($signed(res_prio_r) < $signed(prio_r));
  assign ins_calc    = lt_cnt_r - spq_pkg::CNT_W'(found_below);
  assign ptr_dec     = ptr_r - spq_pkg::CNT_W'(1);
  assign pos_inc     = spq_pkg::CNT_W'(pos_r) + spq_pkg::CNT_W'(1);

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    prio_nxt       = prio_r;
    pay_nxt        = pay_r;
    occ_nxt        = occ_r;
    ptr_nxt        = ptr_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    lt_cnt_nxt     = lt_cnt_r;
    ins_nxt        = ins_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_prio_nxt   = res_prio_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_prio_nxt   = out_prio_r;
    out_pay_nxt    = out_pay_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;

    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = '0;
    mem_req.wr_data = rd_entry;
    mem_req.rd_addr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = spq_pkg::cmd_t'(in_tuser);
          key_nxt        = in_tdata[spq_pkg::KEY_W-1:0];
          prio_nxt       = in_tdata[spq_pkg::KEY_W+spq_pkg::PRIO_W-1:spq_pkg::KEY_W];
          pay_nxt        = in_tdata[spq_pkg::KEY_W+spq_pkg::PRIO_W+spq_pkg::PAY_W-1:
                                    spq_pkg::KEY_W+spq_pkg::PRIO_W];
          ptr_nxt        = '0;
          chk_vld_nxt    = 1'b0;
          found_nxt      = 1'b0;
          lt_cnt_nxt     = '0;
          res_status_nxt = spq_pkg::ST_OK;
          res_key_nxt    = '0;
          res_prio_nxt   = '0;
          res_pay_nxt    = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt    = 1'b1;
          pos_nxt      = chk_idx_r;
          res_key_nxt  = rd_entry.key;
          res_prio_nxt = rd_entry.prio;
          res_pay_nxt  = rd_entry.payload;
        end
        if (below) begin
          lt_cnt_nxt = lt_cnt_r + spq_pkg::CNT_W'(1);
        end
        if (ptr_r < occ_r) begin
          mem_req.rd_addr = ptr_r[spq_pkg::IDX_W-1:0];
          chk_vld_nxt     = 1'b1;
          chk_idx_nxt     = ptr_r[spq_pkg::IDX_W-1:0];
          ptr_nxt         = ptr_r + spq_pkg::CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        case (cmd_r)
          spq_pkg::CMD_INSERT: begin
            res_key_nxt  = '0;
            res_prio_nxt = '0;
            res_pay_nxt  = '0;
            if (found_r) begin
              res_status_nxt = spq_pkg::ST_DUPLICATE;
              state_nxt      = S_DONE;
            end else if (occ_r >= spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
              res_status_nxt = spq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              ins_nxt   = ins_calc;
              ptr_nxt   = occ_r;
              state_nxt = S_UP;
            end
          end
          spq_pkg::CMD_EXTRACT, spq_pkg::CMD_REMOVE: begin
            if (!found_r) begin
              res_status_nxt = spq_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              ptr_nxt   = pos_inc;
              state_nxt = S_DOWN;
            end
          end
          spq_pkg::CMD_CHANGE: begin
            res_key_nxt  = '0;
            res_prio_nxt = '0;
            res_pay_nxt  = '0;
            if (!found_r) begin
              res_status_nxt = spq_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              pay_nxt   = res_pay_r;
              ins_nxt   = ins_calc;
              ptr_nxt   = pos_inc;
              state_nxt = S_DOWN;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DOWN: begin
        if (chk_vld_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = chk_idx_r - spq_pkg::IDX_W'(1);
          mem_req.wr_data = rd_entry;
        end
        if (ptr_r < occ_r) begin
          mem_req.rd_addr = ptr_r[spq_pkg::IDX_W-1:0];
          chk_vld_nxt     = 1'b1;
          chk_idx_nxt     = ptr_r[spq_pkg::IDX_W-1:0];
          ptr_nxt         = ptr_r + spq_pkg::CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            occ_nxt = occ_r - spq_pkg::CNT_W'(1);
            if (cmd_r == spq_pkg::CMD_CHANGE) begin
              ptr_nxt   = occ_r - spq_pkg::CNT_W'(1);
              state_nxt = S_UP;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_UP: begin
        if (chk_vld_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = chk_idx_r + spq_pkg::IDX_W'(1);
          mem_req.wr_data = rd_entry;
        end
        if (ptr_r > ins_r) begin
          mem_req.rd_addr = ptr_dec[spq_pkg::IDX_W-1:0];
          chk_vld_nxt     = 1'b1;
          chk_idx_nxt     = ptr_dec[spq_pkg::IDX_W-1:0];
          ptr_nxt         = ptr_dec;
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            mem_req.wr_en           = 1'b1;
            mem_req.wr_addr         = ins_r[spq_pkg::IDX_W-1:0];
            mem_req.wr_data.key     = key_r;
            mem_req.wr_data.prio    = prio_r;
            mem_req.wr_data.payload = pay_r;
            occ_nxt                 = occ_r + spq_pkg::CNT_W'(1);
            state_nxt               = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_prio_nxt   = res_prio_r;
          out_pay_nxt    = res_pay_r;
          out_empty_nxt  = (occ_r == '0);
          out_count_nxt  = spq_pkg::COUNT_W'(occ_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      cmd_r        <= cmd_nxt;
      key_r        <= key_nxt;
      prio_r       <= prio_nxt;
      pay_r        <= pay_nxt;
      ptr_r        <= ptr_nxt;
      chk_idx_r    <= chk_idx_nxt;
      found_r      <= found_nxt;
      pos_r        <= pos_nxt;
      lt_cnt_r     <= lt_cnt_nxt;
      ins_r        <= ins_nxt;
      res_status_r <= res_status_nxt;
      res_key_r    <= res_key_nxt;
      res_prio_r   <= res_prio_nxt;
      res_pay_r    <= res_pay_nxt;
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_prio_r   <= out_prio_nxt;
      out_pay_r    <= out_pay_nxt;
      out_empty_r  <= out_empty_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = spq_pkg::OUT_DATA_W'({out_count_r, out_pay_r, out_prio_r, out_key_r});
  assign out_tuser  = {out_empty_r, out_status_r};

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("Occupancy exceeds the capacity.");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |->
      (occ_r == $past(occ_r) + spq_pkg::CNT_W'(1) ||
       occ_r == $past(occ_r) - spq_pkg::CNT_W'(1)))
    else $error("Occupancy moved by more than one entry.");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EVAL || state_r == S_IDLE) |-> !mem_req.wr_en)
    else $error("Entry memory written outside a shift.");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != spq_pkg::ST_OK) |->
      (out_key_r == '0 && out_prio_r == '0 && out_pay_r == '0))
    else $error("Failed command returned entry data.");
`endif

endmodule

FILE: bench/tb_sorted_priority_queue_by_key_unit.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the sorted priority queue unit with a shadow queue.
module tb_sorted_priority_queue_by_key_unit;

  localparam int STALL_LIMIT = 4000;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    spq_pkg::status_t                  status;
    logic [spq_pkg::KEY_W-1:0]         key;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::PAY_W-1:0]         payload;
    logic                              empty;
    logic [spq_pkg::COUNT_W-1:0]       count;
  } outcome_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [spq_pkg::CMD_W-1:0]      in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [spq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [spq_pkg::OUT_USER_W-1:0] out_tuser;

  logic [spq_pkg::KEY_W-1:0]         held_keys [spq_pkg::CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0] held_prios [spq_pkg::CAPACITY];
  logic [spq_pkg::PAY_W-1:0]         held_payloads [spq_pkg::CAPACITY];
  int                                held_count;

  outcome_t                  pending_outcomes [$];
  logic [spq_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  bit                        idling_on;
  int                        mismatches;
  int                        stall_cycles;

  sorted_priority_queue_by_key_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_entry(logic [spq_pkg::KEY_W-1:0] key);
    for (int i = 0; i < held_count; i++) begin
      if (held_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_keys[i]     = held_keys[i + 1];
      held_prios[i]    = held_prios[i + 1];
      held_payloads[i] = held_payloads[i + 1];
    end
    held_count--;
  endfunction

  // A new entry goes ahead of every entry of equal priority.
  function automatic void place_entry(logic [spq_pkg::KEY_W-1:0] key,
                                      logic signed [spq_pkg::PRIO_W-1:0] prio,
                                      logic [spq_pkg::PAY_W-1:0] payload);
    int pos;
    pos = 0;
    while (pos < held_count && held_prios[pos] < prio) pos++;
    for (int i = held_count; i > pos; i--) begin
      held_keys[i]     = held_keys[i - 1];
      held_prios[i]    = held_prios[i - 1];
      held_payloads[i] = held_payloads[i - 1];
    end
    held_keys[pos]     = key;
    held_prios[pos]    = prio;
    held_payloads[pos] = payload;
    held_count++;
  endfunction

  function automatic outcome_t compute_queue_outcome(spq_pkg::cmd_t cmd,
                                                     logic [spq_pkg::KEY_W-1:0] key,
                                                     logic signed [spq_pkg::PRIO_W-1:0] prio,
                                                     logic [spq_pkg::PAY_W-1:0] payload);
    outcome_t                  res;
    int                        pos;
    logic [spq_pkg::PAY_W-1:0] kept;
    res = '{spq_pkg::ST_OK, '0, '0, '0, 1'b0, '0};
    pos = find_entry(key);
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        if (pos >= 0) res.status = spq_pkg::ST_DUPLICATE;
        else if (held_count >= spq_pkg::CAPACITY) res.status = spq_pkg::ST_FULL;
        else place_entry(key, prio, payload);
      end
      spq_pkg::CMD_EXTRACT: begin
        if (held_count == 0) begin
          res.status = spq_pkg::ST_NOT_FOUND;
        end else begin
          res.key     = held_keys[0];
          res.prio    = held_prios[0];
          res.payload = held_payloads[0];
          drop_entry(0);
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (pos < 0) begin
          res.status = spq_pkg::ST_NOT_FOUND;
        end else begin
          res.key     = held_keys[pos];
          res.prio    = held_prios[pos];
          res.payload = held_payloads[pos];
          drop_entry(pos);
        end
      end
      spq_pkg::CMD_CHANGE: begin
        if (pos < 0) begin
          res.status = spq_pkg::ST_NOT_FOUND;
        end else begin
          kept = held_payloads[pos];
          drop_entry(pos);
          place_entry(key, prio, kept);
        end
      end
      default: begin
        res.status = spq_pkg::ST_NOT_FOUND;
      end
    endcase
    res.empty = (held_count == 0);
    res.count = held_count[spq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
    if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Narrow priorities give many ties; the rest spans the whole signed range.
  function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return spq_pkg::PRIO_W'($urandom_range(0, 6) - 3);
    if (r < 80) return spq_pkg::PRIO_W'($urandom());
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return 16'sh7FFE;
      default: return 16'sh7FFF;
    endcase
  endfunction

  task automatic send_command(spq_pkg::cmd_t cmd, logic [spq_pkg::KEY_W-1:0] key,
                              logic signed [spq_pkg::PRIO_W-1:0] prio,
                              logic [spq_pkg::PAY_W-1:0] payload);
    int gap;
    gap = idling_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {payload, prio, key};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_outcomes.push_back(compute_queue_outcome(cmd, key, prio, payload));
  endtask

  task automatic send_random(int insert_weight);
    spq_pkg::cmd_t cmd;
    if ($urandom_range(0, 99) < insert_weight) begin
      cmd = spq_pkg::CMD_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0: cmd = spq_pkg::CMD_EXTRACT;
        1: cmd = spq_pkg::CMD_REMOVE;
        default: cmd = spq_pkg::CMD_CHANGE;
      endcase
    end
    send_command(cmd, pick_key(), pick_priority(), $urandom());
  endtask

  task automatic wait_all_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    idling_on = 1'b1;
    send_command(spq_pkg::CMD_EXTRACT, 32'h0000_0000, 16'sh0000, 32'h0000_0000);
    send_command(spq_pkg::CMD_REMOVE,  32'h0000_0000, 16'sh0000, 32'h0000_0000);
    send_command(spq_pkg::CMD_CHANGE,  32'hFFFF_FFFF, 16'sh0000, 32'hFFFF_FFFF);
    send_command(spq_pkg::CMD_INSERT,  32'h0000_0000, 16'sh0000, 32'hFFFF_FFFF);
    send_command(spq_pkg::CMD_INSERT,  32'hFFFF_FFFF, 16'sh8000, 32'h0000_0000);
    send_command(spq_pkg::CMD_INSERT,  32'hA5A5_A5A5, 16'sh7FFF, 32'h5A5A_5A5A);
    send_command(spq_pkg::CMD_INSERT,  32'h5A5A_5A5A, 16'sh0000, 32'hA5A5_A5A5);
    send_command(spq_pkg::CMD_INSERT,  32'h0000_0000, 16'sh0001, 32'h1234_5678);
    send_command(spq_pkg::CMD_CHANGE,  32'hA5A5_A5A5, 16'sh0000, 32'hFFFF_FFFF);
    send_command(spq_pkg::CMD_CHANGE,  32'h1234_5678, 16'sh7FFF, 32'h0000_0000);
    send_command(spq_pkg::CMD_REMOVE,  32'h5A5A_5A5A, 16'sh0000, 32'h0000_0000);
    send_command(spq_pkg::CMD_REMOVE,  32'h5A5A_5A5A, 16'sh7FFF, 32'hFFFF_FFFF);
    repeat (5) send_command(spq_pkg::CMD_EXTRACT, 32'hFFFF_FFFF, 16'sh8000, 32'hFFFF_FFFF);
    wait_all_done();
  endtask

  // Each round fills the queue until inserts are refused, then empties it again.
  task automatic test_fill_and_drain();
    int n;
    idling_on = 1'b1;
    repeat (5) begin
      n = 0;
      while (held_count < spq_pkg::CAPACITY && n < 80) begin
        send_random(90);
        n++;
      end
      repeat (6) send_random(90);
      n = 0;
      while (held_count > 0 && n < 80) begin
        send_random(10);
        n++;
      end
      repeat (3) send_random(10);
    end
    wait_all_done();
  endtask

  task automatic test_mixed_random();
    for (int i = 0; i < 300; i++) begin
      if (i % 40 == 0) idling_on = ($urandom_range(0, 3) != 0);
      send_random(40);
    end
    wait_all_done();
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    repeat (150) send_random(50);
    wait_all_done();
    idling_on = 1'b1;
  endtask

  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = idling_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected result beat, expected none actual %h %h",
                   $time, out_tuser, out_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status",       32'(want.status),  32'(out_tuser[1:0]));
        check_field("queue_empty",  32'(want.empty),   32'(out_tuser[2]));
        check_field("out_key",      want.key,          out_tdata[31:0]);
        check_field("out_priority", 32'(want.prio[15:0]), 32'(out_tdata[47:32]));
        check_field("out_payload",  want.payload,      out_tdata[79:48]);
        check_field("entry_count",  32'(want.count),   32'(out_tdata[84:80]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[sorted_priority_queue_by_key_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = spq_pkg::CMD_INSERT;
    idling_on    = 1'b1;
    held_count   = 0;
    key_pool[0]  = 32'h0000_0000;
    key_pool[1]  = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_fill_and_drain();
    test_mixed_random();
    test_back_to_back();
    repeat (3 * spq_pkg::CAPACITY + 16) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("[sorted_priority_queue_by_key_unit] OK");
    else
      $display("[sorted_priority_queue_by_key_unit] ERROR");
    $finish;
  end

endmodule

FILE: sorted_priority_queue_by_key_unit.f
hdl/spq_pkg.sv
hdl/spq_store.sv
hdl/sorted_priority_queue_by_key_unit.sv
bench/tb_sorted_priority_queue_by_key_unit.sv
